// File: rtl/gzmfc_pkg.sv
`timescale 1ns / 1ps
// gzip member framing checker: shared types, header constants and crc-32 helper
// used by gzip_member_framing_checker; no dependencies

package gzmfc_pkg;

  localparam logic [7:0]  GZ_MAGIC1   = 8'h1f;
  localparam logic [7:0]  GZ_MAGIC2   = 8'h8b;
  localparam logic [7:0]  GZ_DEFLATE  = 8'h08;
  localparam logic [7:0]  GZ_FTEXT    = 8'h01;
  localparam logic [7:0]  GZ_FHCRC    = 8'h02;
  localparam logic [7:0]  GZ_FEXTRA   = 8'h04;
  localparam logic [7:0]  GZ_FNAME    = 8'h08;
  localparam logic [7:0]  GZ_FCOMMENT = 8'h10;
  localparam logic [7:0]  GZ_FRSVD    =
    ~(GZ_FTEXT | GZ_FHCRC | GZ_FEXTRA | GZ_FNAME | GZ_FCOMMENT);
  localparam logic [31:0] GZ_CRC_POLY = 32'hedb88320;

  // optional header parts, in stream order
  localparam logic [2:0] PART_EXTRA   = 3'd0;
  localparam logic [2:0] PART_NAME    = 3'd1;
  localparam logic [2:0] PART_COMMENT = 3'd2;
  localparam logic [2:0] PART_HCRC    = 3'd3;
  localparam logic [2:0] PART_NONE    = 3'd4;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK     = 4'd0,
    ST_HDR    = 4'd1,
    ST_MEMBER = 4'd2,
    ST_WARN   = 4'd3,
    ST_MAGIC  = 4'd4,
    ST_METHOD = 4'd5,
    ST_CRC    = 4'd6,
    ST_LEN    = 4'd7,
    ST_PHASE  = 4'd8,
    ST_HALT   = 4'd9
  } status_e;

  typedef enum logic [13:0] {
    PH_MAG1    = 14'b00000000000001,
    PH_MAG2    = 14'b00000000000010,
    PH_METHOD  = 14'b00000000000100,
    PH_FLAGS   = 14'b00000000001000,
    PH_MTIME   = 14'b00000000010000,
    PH_XFL     = 14'b00000000100000,
    PH_OS      = 14'b00000001000000,
    PH_XLEN    = 14'b00000010000000,
    PH_EXTRA   = 14'b00000100000000,
    PH_NAME    = 14'b00001000000000,
    PH_COMMENT = 14'b00010000000000,
    PH_HCRC    = 14'b00100000000000,
    PH_BODY    = 14'b01000000000000,
    PH_TRAILER = 14'b10000000000000
  } phase_e;

  // byte-wide reflected crc-32 update, pre- and post-inverted
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (GZ_CRC_POLY & {32{c[0]}});
    end
    return ~c;
  endfunction

  // first optional part at or after 'after' that the flags select, else the body
  function automatic phase_e next_part(input logic [2:0] after, input logic [7:0] flags);
    phase_e nxt;
    nxt = PH_BODY;
    if (after <= PART_EXTRA && (flags & GZ_FEXTRA) != 8'd0) begin
      nxt = PH_XLEN;
    end else if (after <= PART_NAME && (flags & GZ_FNAME) != 8'd0) begin
      nxt = PH_NAME;
    end else if (after <= PART_COMMENT && (flags & GZ_FCOMMENT) != 8'd0) begin
      nxt = PH_COMMENT;
    end else if (after <= PART_HCRC && (flags & GZ_FHCRC) != 8'd0) begin
      nxt = PH_HCRC;
    end
    return nxt;
  endfunction

endpackage

// File: rtl/gzip_member_framing_checker.sv
`timescale 1ns / 1ps
// gzip member framing checker: header parse, body crc-32 and length, trailer check
// depends on gzmfc_pkg
//
// usage: one input channel (in_valid_i / in_stall_o) carries items of kind
// framing byte, decompressed data byte or end of compressed body; one output
// channel (out_valid_o / out_stall_i) returns exactly one result per item.
// an item is registered on its transfer, then evaluated against the framing
// state once the result register is free, and its result registered there.
// one item per cycle is sustained while the receiver does not stall; the limit
// is the single byte-wide crc-32 update and phase logic between the registers.
// mod_time_o, crc_value_o and data_length_o show the state left by the item
// whose result is on the port and hold with it.
// reset returns the block to waiting for the first magic byte with all counts
// cleared. an error status halts the block: every later item answers halted
// until reset. while the receiver stalls, the result holds, one more item may
// be taken into the input register, and in_stall_o then rises.

module gzip_member_framing_checker
  import gzmfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic        name_valid_o,
  output logic [7:0]  name_char_o,
  output logic [31:0] mod_time_o,
  output logic [31:0] crc_value_o,
  output logic [31:0] data_length_o
);

  // input register
  logic        in_full_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;

  // framing state
  phase_e      phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] skip_q, skip_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [31:0] time_q, time_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] len_q, len_d;
  logic [31:0] trail_q, trail_d;
  logic        halted_q, halted_d;

  // result register
  logic        out_valid_q;
  status_e     status_q, status_d;
  logic        nvalid_q, nvalid_d;
  logic [7:0]  nchar_q, nchar_d;

  logic        res_ready;
  logic        step;
  logic        take_in;

  logic        go_next;
  logic [2:0]  after;
  phase_e      nxt;
  logic [4:0]  shamt;
  logic [2:0]  bidx_inc;
  logic [15:0] skip_full;
  logic [15:0] skip_dec;

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_full_q && res_ready;
  assign in_stall_o = in_full_q && !res_ready;
  assign take_in    = in_valid_i && !in_stall_o;

  assign shamt     = {bidx_q[1:0], 3'b000};
  assign bidx_inc  = bidx_q + 3'd1;
  assign skip_full = {byte_q, skip_q[7:0]};
  assign skip_dec  = skip_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    skip_d   = skip_q;
    bidx_d   = bidx_q;
    time_d   = time_q;
    crc_d    = crc_q;
    len_d    = len_q;
    trail_d  = trail_q;
    status_d = ST_OK;
    nvalid_d = 1'b0;
    nchar_d  = 8'd0;
    go_next  = 1'b0;
    after    = PART_EXTRA;
    nxt      = PH_BODY;

    if (halted_q) begin
      status_d = ST_HALT;
    end else begin
      case (kind_q)
        KIND_FRAME: begin
          case (phase_q)
            PH_MAG1: begin
              if (byte_q != GZ_MAGIC1) status_d = ST_MAGIC;
              else phase_d = PH_MAG2;
            end
            PH_MAG2: begin
              if (byte_q != GZ_MAGIC2) status_d = ST_MAGIC;
              else phase_d = PH_METHOD;
            end
            PH_METHOD: begin
              if (byte_q != GZ_DEFLATE) status_d = ST_METHOD;
              else phase_d = PH_FLAGS;
            end
            PH_FLAGS: begin
              flags_d = byte_q;
              phase_d = PH_MTIME;
              bidx_d  = 3'd0;
              time_d  = 32'd0;
              if ((byte_q & GZ_FRSVD) != 8'd0) status_d = ST_WARN;
            end
            PH_MTIME: begin
              time_d = time_q | ({24'd0, byte_q} << shamt);
              bidx_d = bidx_inc;
              if (bidx_inc >= 3'd4) begin
                phase_d = PH_XFL;
                bidx_d  = 3'd0;
              end
            end
            PH_XFL: phase_d = PH_OS;
            PH_OS: begin
              go_next = 1'b1;
              after   = PART_EXTRA;
            end
            PH_XLEN: begin
              if (bidx_q == 3'd0) begin
                skip_d = {8'd0, byte_q};
                bidx_d = 3'd1;
              end else begin
                skip_d = skip_full;
                bidx_d = 3'd0;
                if (skip_full == 16'd0) begin
                  go_next = 1'b1;
                  after   = PART_NAME;
                end else begin
                  phase_d = PH_EXTRA;
                end
              end
            end
            PH_EXTRA: begin
              skip_d = skip_dec;
              if (skip_dec == 16'd0) begin
                go_next = 1'b1;
                after   = PART_NAME;
              end
            end
            PH_NAME: begin
              if (byte_q == 8'd0) begin
                go_next = 1'b1;
                after   = PART_COMMENT;
              end else begin
                nvalid_d = 1'b1;
                nchar_d  = byte_q;
              end
            end
            PH_COMMENT: begin
              if (byte_q == 8'd0) begin
                go_next = 1'b1;
                after   = PART_HCRC;
              end
            end
            PH_HCRC: begin
              if (bidx_q == 3'd0) begin
                bidx_d = 3'd1;
              end else begin
                go_next = 1'b1;
                after   = PART_NONE;
              end
            end
            PH_TRAILER: begin
              trail_d = trail_q | ({24'd0, byte_q} << shamt);
              bidx_d  = bidx_inc;
              if (bidx_inc == 3'd4) begin
                if (trail_d != crc_q) status_d = ST_CRC;
                else trail_d = 32'd0;
              end else if (bidx_inc == 3'd0) begin
                if (trail_d != len_q) begin
                  status_d = ST_LEN;
                end else begin
                  trail_d  = 32'd0;
                  phase_d  = PH_MAG1;
                  status_d = ST_MEMBER;
                end
              end
            end
            default: status_d = ST_PHASE;
          endcase
        end
        KIND_DATA: begin
          if (phase_q == PH_BODY) begin
            crc_d = crc32_byte(crc_q, byte_q);
            len_d = len_q + 32'd1;
          end else begin
            status_d = ST_PHASE;
          end
        end
        KIND_END: begin
          if (phase_q == PH_BODY) begin
            phase_d = PH_TRAILER;
            bidx_d  = 3'd0;
            trail_d = 32'd0;
          end else begin
            status_d = ST_PHASE;
          end
        end
        default: status_d = ST_PHASE;
      endcase

      if (go_next) begin
        nxt     = next_part(after, flags_q);
        phase_d = nxt;
        bidx_d  = 3'd0;
        if (nxt == PH_BODY) begin
          crc_d    = 32'd0;
          len_d    = 32'd0;
          status_d = ST_HDR;
        end
      end
    end

    halted_d = halted_q || (status_d inside {[ST_MAGIC:ST_PHASE]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (take_in) begin
      in_full_q <= 1'b1;
    end else if (step) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      kind_q <= kind_i;
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAG1;
      flags_q  <= 8'd0;
      skip_q   <= 16'd0;
      bidx_q   <= 3'd0;
      time_q   <= 32'd0;
      crc_q    <= 32'd0;
      len_q    <= 32'd0;
      trail_q  <= 32'd0;
      halted_q <= 1'b0;
    end else if (step) begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      skip_q   <= skip_d;
      bidx_q   <= bidx_d;
      time_q   <= time_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      trail_q  <= trail_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= in_full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q <= status_d;
      nvalid_q <= nvalid_d;
      nchar_q  <= nchar_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign name_valid_o  = nvalid_q;
  assign name_char_o   = nchar_q;
  assign mod_time_o    = time_q;
  assign crc_value_o   = crc_q;
  assign data_length_o = len_q;

endmodule

// File: test/gzip_member_framing_checker_tb.sv
`timescale 1ns / 1ps
// testbench for gzip_member_framing_checker: well-formed gzip members with random
// content, then one error and halted traffic, all checked against a local predictor
// depends on gzmfc_pkg and the gzip_member_framing_checker rtl

module gzip_member_framing_checker_tb;
  import gzmfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [1:0]  KIND_BAD    = 2'd3;

  typedef struct packed {
    status_e     status;
    logic        name_valid;
    logic [7:0]  name_char;
    logic [31:0] mod_time;
    logic [31:0] crc_value;
    logic [31:0] data_length;
  } frame_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i      = KIND_FRAME;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic        name_valid_o;
  logic [7:0]  name_char_o;
  logic [31:0] mod_time_o;
  logic [31:0] crc_value_o;
  logic [31:0] data_length_o;

  // framing state as the block should hold it
  phase_e      fr_phase   = PH_MAG1;
  logic [7:0]  fr_flags   = 8'd0;
  logic [15:0] fr_skip    = 16'd0;
  logic [2:0]  fr_idx     = 3'd0;
  logic [31:0] fr_time    = 32'd0;
  logic [31:0] fr_crc     = 32'd0;
  logic [31:0] fr_len     = 32'd0;
  logic [31:0] fr_trailer = 32'd0;
  logic        fr_halted  = 1'b0;

  frame_result_t framing_results_q[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned stall_run   = 0;
  int unsigned stall_mode  = 0;

  gzip_member_framing_checker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .name_valid_o  (name_valid_o),
    .name_char_o   (name_char_o),
    .mod_time_o    (mod_time_o),
    .crc_value_o   (crc_value_o),
    .data_length_o (data_length_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = ~crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ GZ_CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return ~r;
  endfunction

  // go to the first selected optional part from first_part on, else into the body
  function automatic status_e open_part(logic [2:0] first_part);
    phase_e nxt;
    nxt = PH_BODY;
    if (first_part <= PART_EXTRA && (fr_flags & GZ_FEXTRA) != 8'd0) begin
      nxt = PH_XLEN;
    end else if (first_part <= PART_NAME && (fr_flags & GZ_FNAME) != 8'd0) begin
      nxt = PH_NAME;
    end else if (first_part <= PART_COMMENT && (fr_flags & GZ_FCOMMENT) != 8'd0) begin
      nxt = PH_COMMENT;
    end else if (first_part <= PART_HCRC && (fr_flags & GZ_FHCRC) != 8'd0) begin
      nxt = PH_HCRC;
    end
    fr_phase = nxt;
    fr_idx   = 3'd0;
    if (nxt == PH_BODY) begin
      fr_crc = 32'd0;
      fr_len = 32'd0;
      return ST_HDR;
    end
    return ST_OK;
  endfunction

  function automatic frame_result_t frame_step(logic [1:0] kind, logic [7:0] b);
    frame_result_t r;
    status_e       st;
    r.name_valid = 1'b0;
    r.name_char  = 8'd0;
    st = ST_OK;
    if (fr_halted) begin
      st = ST_HALT;
    end else if (kind == KIND_FRAME) begin
      case (fr_phase)
        PH_MAG1: begin
          if (b != GZ_MAGIC1) st = ST_MAGIC;
          else fr_phase = PH_MAG2;
        end
        PH_MAG2: begin
          if (b != GZ_MAGIC2) st = ST_MAGIC;
          else fr_phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != GZ_DEFLATE) st = ST_METHOD;
          else fr_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          fr_flags = b;
          fr_phase = PH_MTIME;
          fr_idx   = 3'd0;
          fr_time  = 32'd0;
          if ((b & GZ_FRSVD) != 8'd0) st = ST_WARN;
        end
        PH_MTIME: begin
          fr_time = fr_time | ({24'd0, b} << (8 * fr_idx[1:0]));
          fr_idx  = fr_idx + 3'd1;
          if (fr_idx >= 3'd4) begin
            fr_phase = PH_XFL;
            fr_idx   = 3'd0;
          end
        end
        PH_XFL: fr_phase = PH_OS;
        PH_OS:  st = open_part(PART_EXTRA);
        PH_XLEN: begin
          if (fr_idx == 3'd0) begin
            fr_skip = {8'd0, b};
            fr_idx  = 3'd1;
          end else begin
            fr_skip = {b, fr_skip[7:0]};
            fr_idx  = 3'd0;
            if (fr_skip == 16'd0) st = open_part(PART_NAME);
            else fr_phase = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          fr_skip = fr_skip - 16'd1;
          if (fr_skip == 16'd0) st = open_part(PART_NAME);
        end
        PH_NAME: begin
          if (b == 8'd0) begin
            st = open_part(PART_COMMENT);
          end else begin
            r.name_valid = 1'b1;
            r.name_char  = b;
          end
        end
        PH_COMMENT: begin
          if (b == 8'd0) st = open_part(PART_HCRC);
        end
        PH_HCRC: begin
          if (fr_idx == 3'd0) fr_idx = 3'd1;
          else st = open_part(PART_NONE);
        end
        PH_TRAILER: begin
          fr_trailer = fr_trailer | ({24'd0, b} << (8 * fr_idx[1:0]));
          fr_idx     = fr_idx + 3'd1;
          if (fr_idx == 3'd4) begin
            if (fr_trailer != fr_crc) st = ST_CRC;
            else fr_trailer = 32'd0;
          end else if (fr_idx == 3'd0) begin
            if (fr_trailer != fr_len) begin
              st = ST_LEN;
            end else begin
              fr_trailer = 32'd0;
              fr_phase   = PH_MAG1;
              st         = ST_MEMBER;
            end
          end
        end
        default: st = ST_PHASE;
      endcase
    end else if (kind == KIND_DATA && fr_phase == PH_BODY) begin
      fr_crc = crc32_update(fr_crc, b);
      fr_len = fr_len + 32'd1;
    end else if (kind == KIND_END && fr_phase == PH_BODY) begin
      fr_phase   = PH_TRAILER;
      fr_idx     = 3'd0;
      fr_trailer = 32'd0;
    end else begin
      st = ST_PHASE;
    end
    if (st >= ST_MAGIC && st <= ST_PHASE) fr_halted = 1'b1;
    r.status      = st;
    r.mod_time    = fr_time;
    r.crc_value   = fr_crc;
    r.data_length = fr_len;
    return r;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [7:0] b);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    framing_results_q.push_back(frame_step(kind, b));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (framing_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_header(logic [7:0] flags, logic [31:0] mtime, int unsigned xlen,
                             int unsigned name_len, int unsigned comment_len);
    send_item(KIND_FRAME, GZ_MAGIC1);
    send_item(KIND_FRAME, GZ_MAGIC2);
    send_item(KIND_FRAME, GZ_DEFLATE);
    send_item(KIND_FRAME, flags);
    for (int i = 0; i < 4; i++) send_item(KIND_FRAME, mtime[8*i +: 8]);
    send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
    send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
    if ((flags & GZ_FEXTRA) != 8'd0) begin
      send_item(KIND_FRAME, xlen[7:0]);
      send_item(KIND_FRAME, xlen[15:8]);
      repeat (xlen) send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
    end
    if ((flags & GZ_FNAME) != 8'd0) begin
      repeat (name_len) send_item(KIND_FRAME, 8'($urandom_range(1, 255)));
      send_item(KIND_FRAME, 8'd0);
    end
    if ((flags & GZ_FCOMMENT) != 8'd0) begin
      repeat (comment_len) send_item(KIND_FRAME, 8'($urandom_range(1, 255)));
      send_item(KIND_FRAME, 8'd0);
    end
    if ((flags & GZ_FHCRC) != 8'd0) begin
      send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
      send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_body(int unsigned n);
    repeat (n) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
    send_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // trailer from the predicted crc and length, optionally corrupted
  task automatic send_trailer(logic [31:0] crc_flip, logic [31:0] len_flip);
    logic [31:0] crc_word;
    logic [31:0] len_word;
    crc_word = fr_crc ^ crc_flip;
    len_word = fr_len ^ len_flip;
    for (int i = 0; i < 4; i++) send_item(KIND_FRAME, crc_word[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_item(KIND_FRAME, len_word[8*i +: 8]);
  endtask

  task automatic send_random_member();
    logic [7:0]  flags;
    int unsigned xlen;
    int unsigned n;
    int unsigned pick;
    if ($urandom_range(0, 3) == 0) flags = 8'($urandom_range(0, 255));
    else flags = 8'($urandom_range(0, 31));
    pick = $urandom_range(0, 19);
    if (pick == 0) xlen = 16'h0100 + $urandom_range(0, 3);
    else if (pick < 3) xlen = 0;
    else if (pick < 15) xlen = $urandom_range(1, 6);
    else xlen = $urandom_range(7, 40);
    case ($urandom_range(0, 9))
      0:       n = 0;
      1:       n = $urandom_range(100, 300);
      default: n = $urandom_range(1, 40);
    endcase
    send_header(flags, $urandom, xlen, $urandom_range(0, 8), $urandom_range(0, 6));
    send_body(n);
    send_trailer(32'd0, 32'd0);
  endtask

  task automatic test_directed_member();
    // every optional part, reserved flags, empty extra field, extreme data bytes
    send_header(8'hff, 32'hff00ff00, 0, 1, 1);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_END, 8'hff);
    send_trailer(32'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_random_members();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 1250) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_member();
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_widest_extra();
    gaps_on = 1'b0;
    send_header(GZ_FEXTRA | GZ_FNAME, $urandom, 16'h0140, 3, 0);
    send_body($urandom_range(1, 8));
    send_trailer(32'd0, 32'd0);
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_halt_on_error();
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0: begin
        do b = 8'($urandom_range(0, 255)); while (b == GZ_MAGIC1);
        send_item(KIND_FRAME, b);
      end
      1: begin
        send_item(KIND_FRAME, GZ_MAGIC1);
        do b = 8'($urandom_range(0, 255)); while (b == GZ_MAGIC2);
        send_item(KIND_FRAME, b);
      end
      2: begin
        send_item(KIND_FRAME, GZ_MAGIC1);
        send_item(KIND_FRAME, GZ_MAGIC2);
        do b = 8'($urandom_range(0, 255)); while (b == GZ_DEFLATE);
        send_item(KIND_FRAME, b);
      end
      3: begin
        send_header(8'($urandom_range(0, 31)), $urandom, 2, 2, 2);
        send_body($urandom_range(0, 10));
        send_trailer(32'd1 << $urandom_range(0, 31), 32'd0);
      end
      4: begin
        send_header(8'($urandom_range(0, 31)), $urandom, 2, 2, 2);
        send_body($urandom_range(0, 10));
        send_trailer(32'd0, 32'd1 << $urandom_range(0, 31));
      end
      5: begin
        send_header(8'd0, $urandom, 0, 0, 0);
        repeat ($urandom_range(0, 4)) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        send_item(KIND_FRAME, 8'($urandom_range(0, 255)));
      end
      6: begin
        send_item(KIND_FRAME, GZ_MAGIC1);
        send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      7: send_item(KIND_END, 8'($urandom_range(0, 255)));
      default: begin
        send_header(8'd0, $urandom, 0, 0, 0);
        send_item(KIND_BAD, 8'($urandom_range(0, 255)));
      end
    endcase
    repeat (30) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    drain_results();
  endtask

  // receiver stall pattern, with its character picked anew at random every stretch
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(20, 150);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ((stall_run % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framing_results_q.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", status_o);
        mismatches++;
      end else begin
        want = framing_results_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (name_valid_o !== want.name_valid) begin
          $error("name_valid: expected %0d, got %0d", want.name_valid, name_valid_o);
          mismatches++;
        end
        if (name_char_o !== want.name_char) begin
          $error("name_char: expected %02h, got %02h", want.name_char, name_char_o);
          mismatches++;
        end
        if (mod_time_o !== want.mod_time) begin
          $error("mod_time: expected %08h, got %08h", want.mod_time, mod_time_o);
          mismatches++;
        end
        if (crc_value_o !== want.crc_value) begin
          $error("crc_value: expected %08h, got %08h", want.crc_value, crc_value_o);
          mismatches++;
        end
        if (data_length_o !== want.data_length) begin
          $error("data_length: expected %0d, got %0d", want.data_length, data_length_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gzip_member_framing_checker test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_member();
    test_random_members();
    test_widest_extra();
    test_halt_on_error();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && framing_results_q.size() == 0) begin
      $display("gzip_member_framing_checker test passed");
    end else begin
      $display("gzip_member_framing_checker test failed");
    end
    $finish;
  end

endmodule
